>>> hdl/diff_drive_encoder_odometry_unit_macros.svh
// Assertion macros used by the odometry RTL.
`ifndef DIFF_DRIVE_ENCODER_ODOMETRY_UNIT_MACROS_SVH
`define DIFF_DRIVE_ENCODER_ODOMETRY_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define DDEO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("odometry assertion failed");
`define DDEO_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define DDEO_ASSERT(lbl, prop)
`define DDEO_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

>>> hdl/ddeo_pkg.sv
package ddeo_pkg;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned CNT_W        = $clog2(CORDIC_STEPS + 1);

  localparam logic [31:0]        TURN_PER_RAD = 32'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

  localparam logic [31:0] LTD_RST = 32'd96517639;
  localparam logic [31:0] RTD_RST = 32'd95842752;
  localparam logic [31:0] ITW_RST = 32'd72005220;

  typedef enum logic [1:0] {
    REG_LTD = 2'd0,
    REG_RTD = 2'd1,
    REG_ITW = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cdc_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
  } cdc_sts_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/diff_drive_encoder_odometry_unit.sv
// Differential-drive wheel odometry.
// Input channel (in_valid_i/in_ready_o) carries raw 16-bit left/right encoder
// counters; a request is taken when valid and ready are both high. Output
// channel (out_valid_o/out_ready_i) carries the pose: x, y (signed Q8.24 m,
// saturating) and heading (binary angle). The cfg_we_i/cfg_idx_i/cfg_data_i
// port writes the tick distances and inverse track width; the user must
// write it at idle time only; the block itself does not enforce it. A request
// whose deltas cancel (no motion or spin in place) gives no result and leaves
// pose and counters as they were; the block is ready again next cycle.
// Otherwise the pose is computed step by step and then offered on the output,
// and a new request is taken once it is committed. This takes eight passes
// through one shared 34x34 registered multiplier plus the rotation
// loop, which runs one CORDIC step per cycle. in_ready_o is low meanwhile.
// The pose stays on the output until taken; if the receiver stalls, a
// following request still runs and waits in its final step for the slot.
// Reset clears pose and counters to zero and loads the default constants.
`include "diff_drive_encoder_odometry_unit_macros.svh"

module diff_drive_encoder_odometry_unit import ddeo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        left_count_i,
  input  logic [15:0]        right_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [31:0]        heading_o
);

  typedef enum logic [17:0] {
    S_IDLE = 18'd1,
    S_ML   = 18'd2,
    S_MR   = 18'd4,
    S_SUM  = 18'd8,
    S_ABS  = 18'd16,
    S_T0   = 18'd32,
    S_T1   = 18'd64,
    S_T2   = 18'd128,
    S_K0   = 18'd256,
    S_K1   = 18'd512,
    S_K2   = 18'd1024,
    S_ANG  = 18'd2048,
    S_MID  = 18'd4096,
    S_CST  = 18'd8192,
    S_CORD = 18'd16384,
    S_MX   = 18'd32768,
    S_MY   = 18'd65536,
    S_OUT  = 18'd131072
  } state_e;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [37:0] b);
    logic signed [38:0] s;
    s = {{7{a[31]}}, a} + {b[37], b};
    if (s > 39'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (s < -39'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  state_e             state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        ltd_q, rtd_q, itw_q;
  logic signed [31:0] x_q, x_d, y_q, y_d;
  logic [31:0]        heading_q, heading_d;
  logic [15:0]        last_l_q, last_l_d, last_r_q, last_r_d;

  logic [15:0]        dl_q, dr_q, lc_q, rc_q;
  logic signed [49:0] l_q, diff_q;
  logic signed [32:0] dist_q;
  logic [48:0]        mag_q;
  logic               neg_q;
  logic [49:0]        acc_q;
  logic [31:0]        turn_q, half_q, mid_q;
  logic signed [31:0] xs_q, ys_q;

  logic               accept, go_out;
  logic [15:0]        dl, dr;
  logic [16:0]        dsum;
  logic signed [49:0] r_w, sum_w, abs_w;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  cdc_req_t           cdc_req;
  cdc_sts_t           cdc_sts;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign dl         = left_count_i - last_l_q;
  assign dr         = right_count_i - last_r_q;
  assign dsum       = {dl[15], dl} + {dr[15], dr};
  assign go_out     = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign r_w        = mul_p[49:0];
  assign sum_w      = l_q + r_w;
  assign abs_w      = diff_q[49] ? -diff_q : diff_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ML: begin
        mul_a = {{18{dl_q[15]}}, dl_q};
        mul_b = {2'b00, ltd_q};
      end
      S_MR: begin
        mul_a = {{18{dr_q[15]}}, dr_q};
        mul_b = {2'b00, rtd_q};
      end
      S_T0: begin
        mul_a = {2'b00, mag_q[31:0]};
        mul_b = {2'b00, itw_q};
      end
      S_T1: begin
        mul_a = {17'b0, mag_q[48:32]};
        mul_b = {2'b00, itw_q};
      end
      S_K0: begin
        mul_a = {2'b00, acc_q[31:0]};
        mul_b = {2'b00, TURN_PER_RAD};
      end
      S_K1: begin
        mul_a = {16'b0, acc_q[49:32]};
        mul_b = {2'b00, TURN_PER_RAD};
      end
      S_MX: begin
        mul_a = {dist_q[32], dist_q};
        mul_b = cdc_sts.cos_v;
      end
      // y product held while the pose waits for the output slot
      S_MY, S_OUT: begin
        mul_a = {dist_q[32], dist_q};
        mul_b = cdc_sts.sin_v;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ddeo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign cdc_req.start = (state_q == S_CST);
  assign cdc_req.angle = mid_q;

  ddeo_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cdc_req),
    .sts_o  (cdc_sts)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    x_d         = x_q;
    y_d         = y_q;
    heading_d   = heading_q;
    last_l_d    = last_l_q;
    last_r_d    = last_r_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (dsum != 17'd0)) begin
          state_d = S_ML;
        end
      end
      S_ML:  state_d = S_MR;
      S_MR:  state_d = S_SUM;
      S_SUM: state_d = S_ABS;
      S_ABS: state_d = S_T0;
      S_T0:  state_d = S_T1;
      S_T1:  state_d = S_T2;
      S_T2:  state_d = S_K0;
      S_K0:  state_d = S_K1;
      S_K1:  state_d = S_K2;
      S_K2:  state_d = S_ANG;
      S_ANG: state_d = S_MID;
      S_MID: state_d = S_CST;
      S_CST: state_d = S_CORD;
      S_CORD: begin
        if (cdc_sts.done) begin
          state_d = S_MX;
        end
      end
      S_MX:  state_d = S_MY;
      S_MY:  state_d = S_OUT;
      S_OUT: begin
        if (go_out) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          x_d         = xs_q;
          y_d         = sat_add(y_q, mul_p[67:30]);
          heading_d   = heading_q + turn_q;
          last_l_d    = lc_q;
          last_r_d    = rc_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      heading_q   <= '0;
      last_l_q    <= '0;
      last_r_q    <= '0;
      ltd_q       <= LTD_RST;
      rtd_q       <= RTD_RST;
      itw_q       <= ITW_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      x_q         <= x_d;
      y_q         <= y_d;
      heading_q   <= heading_d;
      last_l_q    <= last_l_d;
      last_r_q    <= last_r_d;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_LTD: ltd_q <= cfg_data_i;
          REG_RTD: rtd_q <= cfg_data_i;
          REG_ITW: itw_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dl_q <= dl;
      dr_q <= dr;
      lc_q <= left_count_i;
      rc_q <= right_count_i;
    end
    case (state_q)
      S_MR:  l_q <= mul_p[49:0];
      S_SUM: begin
        dist_q <= sum_w[49:17];
        diff_q <= r_w - l_q;
      end
      S_ABS: begin
        mag_q <= abs_w[48:0];
        neg_q <= diff_q[49];
      end
      S_T1:  acc_q <= {18'b0, mul_p[63:32]};
      S_T2:  acc_q <= acc_q + mul_p[49:0];
      S_K1:  acc_q <= {18'b0, mul_p[63:32]};
      S_K2:  acc_q <= acc_q + mul_p[49:0];
      S_ANG: begin
        turn_q <= neg_q ? -acc_q[31:0] : acc_q[31:0];
        half_q <= neg_q ? -acc_q[32:1] : acc_q[32:1];
      end
      S_MID: mid_q <= heading_q + half_q;
      S_MY:  xs_q  <= sat_add(x_q, mul_p[67:30]);
      default: ;
    endcase
  end

  assign ys_q        = y_q;
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = x_q;
  assign pos_y_o     = ys_q;
  assign heading_o   = heading_q;

  `DDEO_ASSERT(a_out_after_commit, $rose(out_valid_o) |-> $past(state_q == S_OUT))
  `DDEO_ASSERT(a_cordic_done_in_wait, cdc_sts.done |-> state_q == S_CORD)
  `DDEO_ASSERT_MSG(a_pose_commit_only, !$stable(heading_q) |-> $past(state_q == S_OUT), "heading moved outside commit")

endmodule

>>> hdl/ddeo_mul.sv
module ddeo_mul import ddeo_pkg::*; (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);

  logic signed [67:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> hdl/ddeo_cordic.sv
module ddeo_cordic import ddeo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cdc_req_t req_i,
  output cdc_sts_t sts_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               flip_q, flip_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [33:0] xs, ys, at;
  logic [4:0]         idx;
  logic               flip_in;
  logic [31:0]        ang_red;

  assign idx     = 5'(cnt_q);
  assign xs      = x_q >>> idx;
  assign ys      = y_q >>> idx;
  assign at      = {2'b00, atan_entry(idx)};
  // angle + quarter turn lands in the upper half: rotate by a half turn
  assign flip_in = req_i.angle[31] ^ req_i.angle[30];
  assign ang_red = flip_in ? {~req_i.angle[31], req_i.angle[30:0]} : req_i.angle;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    flip_d = flip_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      flip_d = flip_in;
      cnt_d  = '0;
      x_d    = CORDIC_GAIN;
      y_d    = '0;
      z_d    = {{2{ang_red[31]}}, ang_red};
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(CORDIC_STEPS)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (flip_q) begin
          x_d = -x_q;
          y_d = -y_q;
        end
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (!z_q[33]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign sts_o.done  = done_q;
  assign sts_o.cos_v = x_q;
  assign sts_o.sin_v = y_q;

endmodule
